/* sv/skl_pkg.sv */
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and codes for the sorted key list.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned STS_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_SEARCH    = 3'd2,
    ACT_LIST_ASC  = 3'd3,
    ACT_LIST_DESC = 3'd4
  } action_t;

  typedef enum logic [STS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_LIST
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic commit;
    logic list_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic act_ok;
    logic list_go;
    logic out_free;
    logic pos_tag;
    logic list_last;
  } sts_t;

endpackage

/* sv/sorted_key_list.sv */
// ----------------------------------------------------------------------------
// sorted_key_list
// Ascending store of signed keys with insert, remove, search and listing.
//
//   channel | dir | tdata        | tuser         | tlast
//   in_     | in  | [31:0] key   | [2:0] action  | -
//   out_    | out | [31:0] key   | [2:0] status  | last result of the request
//
// Insert, remove, search: accept, then one compare/shift of all cells. Listing:
// accept, commit, then one step per stored key (ascending) or CAPACITY steps
// (descending, unload register shifting toward its top end), one place a cycle;
// a stalled out_ side holds the sequencer. One request at a time; the next is
// taken once the last result is registered. Reset clears count, tags, valid, state.
// ----------------------------------------------------------------------------
module sorted_key_list
  import skl_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] key_out
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;

  skl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_tuser),
    .in_key     (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_key    (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

/* sv/skl_ctrl.sv */
// ----------------------------------------------------------------------------
// skl_ctrl
// Request sequencer: accept, commit one operation, then step a listing.
// ----------------------------------------------------------------------------
module skl_ctrl
  import skl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          if (sts.act_ok) begin
            state_nxt = S_OP;
          end
        end
      end
      S_OP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.list_go ? S_LIST : S_IDLE;
        end
      end
      S_LIST: begin
        if (!sts.pos_tag || sts.out_free) begin
          cmd.list_step = 1'b1;
          if (sts.pos_tag && sts.list_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/skl_dp.sv */
// ----------------------------------------------------------------------------
// skl_dp
// Shift-cell sorted store, list unload register and result register.
// ----------------------------------------------------------------------------
module skl_dp
  import skl_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [ACT_W-1:0] in_action,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [STS_W-1:0] out_status,
  output logic [KEY_W-1:0] out_key,
  output logic             out_last
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // request
  action_t                  act_r;
  logic signed [KEY_W-1:0]  req_key_r;

  // sorted cells
  logic signed [KEY_W-1:0]  cell_r   [CAPACITY];
  logic signed [KEY_W-1:0]  cell_nxt [CAPACITY];
  logic signed [KEY_W-1:0]  cell_dn  [CAPACITY];
  logic signed [KEY_W-1:0]  cell_up  [CAPACITY];
  logic [CW-1:0]            count_r, count_nxt;

  logic [CAPACITY-1:0]      valid, lt, eq, ge, lt_sh, ge_sh, at_slot;
  logic                     found, full, empty, is_list;
  logic                     do_ins, do_rem;

  // list unload
  logic [KEY_W-1:0]         list_r [CAPACITY];
  logic [CAPACITY-1:0]      tag_r;
  logic                     desc_r;
  logic [CW-1:0]            remain_r;
  logic [KEY_W-1:0]         pos_key;

  // result register
  logic                     out_valid_r;
  logic [STS_W-1:0]         out_status_r;
  logic [KEY_W-1:0]         out_key_r;
  logic                     out_last_r;
  logic                     out_free, emit_op, emit_list;
  status_t                  op_status;
  logic [KEY_W-1:0]         op_key;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (CW'(i) < count_r);
      lt[i]    = valid[i] && (cell_r[i] < req_key_r);
      eq[i]    = valid[i] && (cell_r[i] == req_key_r);
      ge[i]    = valid[i] && !lt[i];
      cell_dn[i] = cell_r[i];
      cell_up[i] = cell_r[i];
      if (i > 0) begin
        cell_dn[i] = cell_r[i-1];
      end
      if (i < CAPACITY - 1) begin
        cell_up[i] = cell_r[i+1];
      end
    end
  end

  assign lt_sh   = {lt[CAPACITY-2:0], 1'b1};
  assign ge_sh   = {ge[CAPACITY-2:0], 1'b0};
  assign at_slot = ~lt & lt_sh;
  assign found   = |eq;
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign is_list = (act_r == ACT_LIST_ASC) || (act_r == ACT_LIST_DESC);
  assign do_ins  = cmd.commit && (act_r == ACT_INSERT) && !full;
  assign do_rem  = cmd.commit && (act_r == ACT_REMOVE) && found;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins) begin
        if (ge_sh[i]) begin
          cell_nxt[i] = cell_dn[i];
        end else if (at_slot[i]) begin
          cell_nxt[i] = req_key_r;
        end
      end else if (do_rem && ge[i]) begin
        cell_nxt[i] = cell_up[i];
      end
    end
  end

  always_comb begin
    op_status = ST_NOT_FOUND;
    op_key    = req_key_r;
    case (act_r)
      ACT_INSERT:    op_status = full ? ST_FULL : ST_INSERTED;
      ACT_REMOVE:    op_status = found ? ST_REMOVED : ST_NOT_FOUND;
      ACT_SEARCH:    op_status = found ? ST_FOUND : ST_NOT_FOUND;
      ACT_LIST_ASC,
      ACT_LIST_DESC: begin
        op_status = ST_EMPTY;
        op_key    = '0;
      end
      default:       op_status = ST_NOT_FOUND;
    endcase
  end

  assign pos_key   = desc_r ? list_r[CAPACITY-1] : list_r[0];
  assign out_free  = !out_valid_r || out_ready;
  assign emit_op   = cmd.commit && !(is_list && !empty);
  assign emit_list = cmd.list_step && sts.pos_tag;

  assign sts.act_ok    = in_action inside {[ACT_INSERT:ACT_LIST_DESC]};
  assign sts.list_go   = is_list && !empty;
  assign sts.out_free  = out_free;
  assign sts.pos_tag   = desc_r ? tag_r[CAPACITY-1] : tag_r[0];
  assign sts.list_last = (remain_r == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r     <= action_t'(in_action);
      req_key_r <= in_key;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (cmd.commit) begin
      desc_r   <= (act_r == ACT_LIST_DESC);
      remain_r <= count_r;
      for (int i = 0; i < CAPACITY; i++) begin
        list_r[i] <= cell_r[i];
      end
    end else if (cmd.list_step) begin
      if (sts.pos_tag) begin
        remain_r <= remain_r - CW'(1);
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (desc_r) begin
          if (i > 0) begin
            list_r[i] <= list_r[i-1];
          end
        end else if (i < CAPACITY - 1) begin
          list_r[i] <= list_r[i+1];
        end
      end
    end
    if (emit_op) begin
      out_status_r <= op_status;
      out_key_r    <= op_key;
      out_last_r   <= 1'b1;
    end else if (emit_list) begin
      out_status_r <= ST_ENTRY;
      out_key_r    <= pos_key;
      out_last_r   <= sts.list_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.commit) begin
        tag_r <= (is_list && !empty) ? valid : '0;
      end else if (cmd.list_step) begin
        tag_r <= desc_r ? {tag_r[CAPACITY-2:0], 1'b0} : {1'b0, tag_r[CAPACITY-1:1]};
      end
      if (emit_op || emit_list) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_last   = out_last_r;

endmodule
